### src/hlps_pkg.sv
package hlps_pkg;

   // Item kinds carried in the request tuser
   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2,
      OP_LINE  = 2'd3
   } hlps_op_type;

   // Link register ports
   localparam logic [2:0] PORT_PDATA  = 3'd0;
   localparam logic [2:0] PORT_DIR    = 3'd1;
   localparam logic [2:0] PORT_TXDATA = 3'd2;
   localparam logic [2:0] PORT_RXDATA = 3'd3;
   localparam logic [2:0] PORT_CTRL   = 3'd4;

   // Configuration register indexes (byte address = 4 * index)
   localparam int unsigned HLPS_CSR_ADDR_W = 5;
   localparam logic [2:0] CSR_LINK_EMULATED = 3'd0;
   localparam logic [2:0] CSR_DELAY_RATE0   = 3'd1;
   localparam logic [2:0] CSR_DELAY_RATE1   = 3'd2;
   localparam logic [2:0] CSR_DELAY_RATE2   = 3'd3;
   localparam logic [2:0] CSR_DELAY_RATE3   = 3'd4;

   localparam int unsigned HLPS_PARALLEL_DELAY = 30;

   typedef struct packed {
      logic              link_emulated;
      logic [3:0][15:0]  delay_rate;
   } hlps_cfg_type;

   typedef struct packed {
      hlps_op_type operation;
      logic [2:0]  port;
      logic [7:0]  write_data;
      logic [2:0]  rx_line;
      logic        rx_value;
      logic        rx_serial;
   } hlps_req_type;

   typedef struct packed {
      logic       nmi_request;
      logic [6:0] parallel_out_data;
      logic [6:0] parallel_out_mask;
      logic       parallel_out_valid;
      logic       serial_out_bit;
      logic       serial_out_valid;
      logic [7:0] read_data;
   } hlps_rsp_type;

endpackage

### src/hlps_csr.sv
module hlps_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [hlps_pkg::HLPS_CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready,
   output hlps_pkg::hlps_cfg_type               cfg
);
   import hlps_pkg::*;

   logic             link_emulated_ff, link_emulated_in;
   logic [3:0][15:0] delay_rate_ff, delay_rate_in;
   logic [2:0]       idx;
   logic             wr_en;

   assign idx        = csr_paddr[HLPS_CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      link_emulated_in = link_emulated_ff;
      delay_rate_in    = delay_rate_ff;
      csr_prdata       = '0;
      case (idx)
         CSR_LINK_EMULATED: begin
            csr_prdata = {31'd0, link_emulated_ff};
            if (wr_en) link_emulated_in = csr_pwdata[0];
         end
         CSR_DELAY_RATE0: begin
            csr_prdata = {16'd0, delay_rate_ff[0]};
            if (wr_en) delay_rate_in[0] = csr_pwdata[15:0];
         end
         CSR_DELAY_RATE1: begin
            csr_prdata = {16'd0, delay_rate_ff[1]};
            if (wr_en) delay_rate_in[1] = csr_pwdata[15:0];
         end
         CSR_DELAY_RATE2: begin
            csr_prdata = {16'd0, delay_rate_ff[2]};
            if (wr_en) delay_rate_in[2] = csr_pwdata[15:0];
         end
         CSR_DELAY_RATE3: begin
            csr_prdata = {16'd0, delay_rate_ff[3]};
            if (wr_en) delay_rate_in[3] = csr_pwdata[15:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_emulated_ff <= 1'b1;
         delay_rate_ff[0] <= 16'd2048;
         delay_rate_ff[1] <= 16'd4096;
         delay_rate_ff[2] <= 16'd8192;
         delay_rate_ff[3] <= 16'd32768;
      end else begin
         link_emulated_ff <= link_emulated_in;
         delay_rate_ff    <= delay_rate_in;
      end
   end

   assign cfg.link_emulated = link_emulated_ff;
   assign cfg.delay_rate    = delay_rate_ff;

endmodule

### src/hlps_core.sv
module hlps_core #(
   parameter int unsigned PARALLEL_DELAY = hlps_pkg::HLPS_PARALLEL_DELAY
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hlps_pkg::hlps_cfg_type cfg,
   input  logic                   item_valid,
   input  hlps_pkg::hlps_req_type item,
   output hlps_pkg::hlps_rsp_type rsp
);
   import hlps_pkg::*;

   typedef struct packed {
      logic [7:0]  pdata;
      logic [7:0]  dir;
      logic [7:0]  txd;
      logic [7:0]  rxd;
      logic [7:0]  ctrl;
      logic [15:0] sdc;
      logic [4:0]  pdc;
      logic [3:0]  tx_left;
      logic [2:0]  rx_seen;
      logic [7:0]  tx_shift;
      logic [7:0]  rx_shift;
      logic        tx_full;
      logic        par_armed;
      logic        ser_armed;
   } hlps_state_type;

   localparam hlps_state_type STATE_RESET = '{
      pdata:     8'h7f,
      dir:       8'hff,
      txd:       8'h00,
      rxd:       8'hff,
      ctrl:      8'h00,
      sdc:       16'h0000,
      pdc:       5'd0,
      tx_left:   4'd0,
      rx_seen:   3'd0,
      tx_shift:  8'h00,
      rx_shift:  8'h00,
      tx_full:   1'b0,
      par_armed: 1'b0,
      ser_armed: 1'b1
   };

   hlps_state_type state_ff, state_in;
   logic [6:0]     mask;
   logic [15:0]    baud;
   logic [2:0]     line;

   // Lines driven toward the partner
   function automatic logic [6:0] out_mask(input logic [7:0] ctrl, input logic [7:0] dir);
      logic [6:0] m;
      m = ~dir[6:0];
      if (ctrl[5]) m[5] = 1'b0;
      if (ctrl[4]) m[4] = 1'b1;
      return m;
   endfunction

   // Fixed cable swap of the partner's line numbers
   function automatic logic [2:0] line_swap(input logic [2:0] raw);
      logic [2:0] n;
      case (raw)
         3'd0:    n = 3'd2;
         3'd1:    n = 3'd3;
         3'd2:    n = 3'd0;
         3'd3:    n = 3'd1;
         3'd4:    n = 3'd5;
         3'd5:    n = 3'd4;
         default: n = raw;
      endcase
      return n;
   endfunction

   always_comb begin
      state_in = state_ff;
      rsp      = '0;
      mask     = out_mask(state_ff.ctrl, state_ff.dir);
      baud     = cfg.delay_rate[state_ff.ctrl[7:6]];
      line     = line_swap(item.rx_line);

      case (item.operation)
         OP_READ: begin
            case (item.port)
               PORT_PDATA:  rsp.read_data = state_ff.pdata;
               PORT_DIR:    rsp.read_data = state_ff.dir;
               PORT_TXDATA: rsp.read_data = state_ff.txd;
               PORT_RXDATA: begin
                  rsp.read_data      = state_ff.rxd;
                  state_in.ser_armed = 1'b1;
                  state_in.ctrl[1]   = 1'b0;
               end
               PORT_CTRL:   rsp.read_data = state_ff.ctrl;
               default: ;
            endcase
         end
         OP_WRITE: begin
            case (item.port)
               PORT_PDATA: begin
                  state_in.pdata = {item.write_data[7],
                                    (state_ff.pdata[6:0] & ~mask) | (item.write_data[6:0] & mask)};
                  state_in.pdc   = 5'(PARALLEL_DELAY);
               end
               PORT_DIR: begin
                  if (state_ff.dir[7] && !item.write_data[7]) state_in.par_armed = 1'b1;
                  state_in.dir = item.write_data;
               end
               PORT_TXDATA: begin
                  state_in.txd = item.write_data;
                  if (state_ff.ctrl[4]) begin
                     if (state_ff.tx_left == 4'd0) begin
                        state_in.tx_shift = item.write_data;
                        state_in.tx_left  = 4'd8;
                     end else begin
                        state_in.tx_full = 1'b1;
                     end
                     if (state_ff.sdc == 16'd0) state_in.sdc = baud;
                     state_in.ctrl[0] = cfg.link_emulated;
                  end
               end
               PORT_CTRL: state_in.ctrl = {item.write_data[7:3], state_ff.ctrl[2:0]};
               default: ;
            endcase
         end
         OP_TICK: begin
            if (state_ff.sdc != 16'd0) begin
               state_in.sdc = state_ff.sdc - 16'd1;
               if (state_ff.sdc == 16'd1) begin
                  if (state_ff.tx_left != 4'd0) begin
                     rsp.serial_out_valid = 1'b1;
                     rsp.serial_out_bit   = state_ff.tx_shift[7];
                     if (state_ff.tx_left == 4'd1) state_in.ctrl[0] = 1'b0;
                     state_in.tx_left = state_ff.tx_left - 4'd1;
                  end
                  if (state_in.tx_left != 4'd0) begin
                     state_in.tx_shift = {state_ff.tx_shift[6:0], 1'b0};
                     state_in.sdc      = baud;
                  end else if (state_ff.tx_full) begin
                     // buffered byte moves into the shifter
                     state_in.tx_full  = 1'b0;
                     state_in.tx_left  = 4'd8;
                     state_in.sdc      = baud;
                     state_in.tx_shift = state_ff.txd;
                     state_in.ctrl[0]  = 1'b1;
                  end
               end
            end
            if (state_ff.pdc != 5'd0) begin
               state_in.pdc = state_ff.pdc - 5'd1;
               if (state_ff.pdc == 5'd1) begin
                  rsp.parallel_out_valid = 1'b1;
                  rsp.parallel_out_mask  = mask;
                  rsp.parallel_out_data  = state_ff.pdata[6:0];
               end
            end
         end
         OP_LINE: begin
            if (item.rx_serial && state_ff.ctrl[5]) begin
               state_in.rx_shift = {state_ff.rx_shift[6:0], item.rx_value};
               state_in.rx_seen  = state_ff.rx_seen + 3'd1;
               if (state_ff.rx_seen == 3'd7) begin
                  state_in.rxd     = {state_ff.rx_shift[6:0], item.rx_value};
                  state_in.ctrl[1] = 1'b1;
                  if (state_ff.ctrl[3] && state_ff.ser_armed) begin
                     rsp.nmi_request    = 1'b1;
                     state_in.ser_armed = 1'b0;
                  end
               end
            end
            if (line != 3'd7) begin
               // line six as an input: one-shot nmi on a level change
               if (line == 3'd6 && state_ff.dir[6] && state_ff.par_armed &&
                   item.rx_value != state_ff.pdata[6]) begin
                  state_in.par_armed = 1'b0;
                  rsp.nmi_request    = 1'b1;
               end
               state_in.pdata[line] = item.rx_value;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (item_valid) begin
         state_ff <= state_in;
      end
   end

   a_tx_left_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.tx_left <= 4'd8)
      else $error("transmit bit count out of range");

   a_buffer_needs_shifter: assert property (@(posedge clock) disable iff (reset)
      state_ff.tx_full |-> state_ff.tx_left != 4'd0)
      else $error("transmit buffer full with idle shifter");

   a_rx_read_clears_full: assert property (@(posedge clock) disable iff (reset)
      item_valid && item.operation == OP_READ && item.port == PORT_RXDATA
      |=> !state_ff.ctrl[1] && state_ff.ser_armed)
      else $error("rx data read did not clear full flag");

endmodule

### src/hlps_skid.sv
module hlps_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  hlps_pkg::hlps_rsp_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output hlps_pkg::hlps_rsp_type out_data
);
   import hlps_pkg::*;

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   hlps_rsp_type out_data_ff, out_data_in;
   hlps_rsp_type skid_data_ff, skid_data_in;
   logic         take;

   assign in_ready = !skid_valid_ff;
   assign take     = in_valid && in_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (take) begin
         if (out_valid_ff && !out_ready) begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end else begin
            out_valid_in = 1'b1;
            out_data_in  = in_data;
         end
      end else if (out_ready) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry without output entry");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      take && out_valid_ff && !out_ready |=> skid_valid_ff)
      else $error("transfer lost during output stall");

   a_drain_from_skid: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_ready |=> out_valid_ff && !skid_valid_ff)
      else $error("skid entry not drained");

endmodule

### src/handheld_link_port_serial_parallel_top.sv
// Handheld link port: five byte link registers (parallel data, direction
// with active-low NMI enable in bit 7, tx data, rx data, serial control)
// driven by a stream of items: register read, register write, time tick, or
// a line change from the partner. Every accepted item yields exactly one
// result transfer. The block takes one item per clock while req_tready is
// high. Link state updates at the accepting edge, which also captures the
// result in the output register (offered on rsp_tvalid from the next cycle)
// or, if that register is stalled, in the skid entry. req_tready stays high
// while a single result waits on rsp_tready and drops only when both entries
// are occupied. Baud delays and the emulation flag live in an APB register
// file; the user must write it only while the stream is idle, which the block
// does not enforce. No clearing pass is needed after reset.
module handheld_link_port_serial_parallel_top #(
   parameter int unsigned PARALLEL_DELAY = hlps_pkg::HLPS_PARALLEL_DELAY
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [2:0] port, [10:3] write_data, [13:11] rx_line, [14] rx_value, [15] zero
   input  logic [15:0]                          req_tdata,
   // [1:0] operation, [2] rx_serial
   input  logic [2:0]                           req_tuser,
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [7:0] read_data, [8] serial_out_valid, [9] serial_out_bit,
   // [10] parallel_out_valid, [17:11] parallel_out_mask,
   // [24:18] parallel_out_data, [25] nmi_request, [31:26] zero
   output logic [31:0]                          rsp_tdata,
   // configuration
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [hlps_pkg::HLPS_CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import hlps_pkg::*;

   hlps_cfg_type cfg;
   hlps_req_type item;
   hlps_rsp_type core_rsp;
   hlps_rsp_type out_rsp;
   logic         item_valid;

   // Unpack the request transfer
   assign item.operation  = hlps_op_type'(req_tuser[1:0]);
   assign item.rx_serial  = req_tuser[2];
   assign item.port       = req_tdata[2:0];
   assign item.write_data = req_tdata[10:3];
   assign item.rx_line    = req_tdata[13:11];
   assign item.rx_value   = req_tdata[14];

   assign item_valid = req_tvalid && req_tready;

   hlps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Link state and per-item result logic
   hlps_core #(
      .PARALLEL_DELAY (PARALLEL_DELAY)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .rsp        (core_rsp)
   );

   // Result register with skid entry
   hlps_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (core_rsp),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_rsp)
   );

   assign rsp_tdata = {6'd0,
                       out_rsp.nmi_request,
                       out_rsp.parallel_out_data,
                       out_rsp.parallel_out_mask,
                       out_rsp.parallel_out_valid,
                       out_rsp.serial_out_bit,
                       out_rsp.serial_out_valid,
                       out_rsp.read_data};

endmodule
